@@ rtl/drcq_pkg.sv @@
// drcq_pkg: shared types and constants for the dirty rectangle clip queue.
// No dependencies; imported by the interfaces and every module in rtl/.
package drcq_pkg;

    localparam int unsigned CoordW  = 12;
    localparam int unsigned InW     = 16;
    localparam int unsigned SlotW   = 3;
    localparam int unsigned CountW  = 4;
    localparam int unsigned CfgAddrW = 3;
    localparam int unsigned CfgDataW = 32;

    localparam logic [CoordW-1:0] FbWidthRst  = 12'd800;
    localparam logic [CoordW-1:0] FbHeightRst = 12'd600;

    // Item kinds on the input channel
    typedef enum logic [1:0] {
        KIND_UPDATE = 2'd0,
        KIND_READ   = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    // Result status codes
    typedef enum logic [2:0] {
        STAT_STORED   = 3'd0,
        STAT_ABSORBED = 3'd1,
        STAT_IGNORED  = 3'd2,
        STAT_READ     = 3'd3,
        STAT_CLEARED  = 3'd4
    } status_t;

    // Configuration register indexes (byte address / 4)
    typedef enum logic {
        REG_FB_WIDTH  = 1'b0,
        REG_FB_HEIGHT = 1'b1
    } reg_idx_t;

    // One stored rectangle
    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [CoordW-1:0] w;
        logic [CoordW-1:0] h;
    } rect_t;

    // Clip unit verdict for an update item
    typedef struct packed {
        logic  bogus;    // negative width or height after clipping
        logic  clipped;  // clipping altered some field
        logic  scroll;   // full width and more than half the height
        rect_t rect;
    } clip_res_t;

endpackage

@@ rtl/drcq_if.sv @@
// drcq_in_if / drcq_out_if: valid/ready channels for input items and results.
// Depends on drcq_pkg.
interface drcq_in_if
    import drcq_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [1:0]                kind;
    logic signed [InW-1:0]     rect_x;
    logic signed [InW-1:0]     rect_y;
    logic signed [InW-1:0]     rect_w;
    logic signed [InW-1:0]     rect_h;
    logic [SlotW-1:0]          slot_index;

    modport source (output valid, kind, rect_x, rect_y, rect_w, rect_h, slot_index,
                    input ready);
    modport sink   (input valid, kind, rect_x, rect_y, rect_w, rect_h, slot_index,
                    output ready);
endinterface

interface drcq_out_if
    import drcq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [2:0]          status;
    logic                was_clipped;
    logic [CoordW-1:0]   out_x;
    logic [CoordW-1:0]   out_y;
    logic [CoordW-1:0]   out_w;
    logic [CoordW-1:0]   out_h;
    logic [SlotW-1:0]    out_slot;
    logic [CountW-1:0]   queued_count;
    logic                full_redraw;

    modport source (output valid, status, was_clipped, out_x, out_y, out_w, out_h,
                    out_slot, queued_count, full_redraw, input ready);
    modport sink   (input valid, status, was_clipped, out_x, out_y, out_w, out_h,
                    out_slot, queued_count, full_redraw, output ready);
endinterface

@@ rtl/dirty_rect_clip_queue_unit.sv @@
// dirty_rect_clip_queue_unit: top level of the dirty rectangle clip queue.
// Depends on drcq_pkg, drcq_if, drcq_cfg, drcq_clip and drcq_rect_mem.
//
//  channel  | dir | handshake            | carries
//  ---------+-----+----------------------+-------------------------------------
//  in_ch    | in  | valid/ready          | kind, rect_x/y/w/h, slot_index
//  out_ch   | out | valid/ready          | status, was_clipped, out_x/y/w/h,
//           |     |                      | out_slot, queued_count, full_redraw
//  apb      | in  | psel/penable, pready | fb_width @0x0, fb_height @0x4
//
// Timing: update, clear and unused kinds are written to the result register on
// acceptance; a slot read goes through the store's registered read port and
// S_READ_WAIT first. One item is in flight at a time, so the next is taken once
// the result register is free (the same cycle it is taken downstream).
// Reset: count and full-redraw flag clear, registers return to 800 x 600; the
// store needs no clearing pass (its contents are undefined until written).
// Stalls: out_ch.ready low holds the result and blocks in_ch.ready.
module dirty_rect_clip_queue_unit
    import drcq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    drcq_in_if.sink             in_ch,
    drcq_out_if.source          out_ch,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [CfgDataW-1:0] pwdata,
    output logic [CfgDataW-1:0] prdata,
    output logic                pready
);

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SlotCmpW = 8;

    typedef enum logic {
        S_IDLE,
        S_READ_WAIT
    } state_t;

    state_t            state_reg;
    logic              out_valid_reg;
    status_t           status_reg;
    logic              clipped_reg;
    rect_t             rect_reg;
    logic [SlotW-1:0]  slot_reg;
    logic [CW-1:0]     count_reg;
    logic              redraw_reg;
    logic              rd_oob_reg;

    logic [CoordW-1:0] fb_width;
    logic [CoordW-1:0] fb_height;
    clip_res_t         clip;
    rect_t             rd_data;

    logic              in_acc;
    logic              out_acc;
    logic              queue_full;
    logic              slot_oob;
    logic              wr_en;
    logic              rd_en;
    logic              out_valid_next;

    // Next-state decision for items that finish in the accept cycle
    status_t           status_next;
    logic              clipped_next;
    rect_t             rect_next;
    logic [SlotW-1:0]  slot_next;
    logic [CW-1:0]     count_next;
    logic              redraw_next;

    drcq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .fb_width  (fb_width),
        .fb_height (fb_height)
    );

    drcq_clip u_clip (
        .rect_x    (in_ch.rect_x),
        .rect_y    (in_ch.rect_y),
        .rect_w    (in_ch.rect_w),
        .rect_h    (in_ch.rect_h),
        .fb_width  (fb_width),
        .fb_height (fb_height),
        .res       (clip)
    );

    drcq_rect_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (clip.rect),
        .rd_en   (rd_en),
        .rd_addr (AW'(in_ch.slot_index)),
        .rd_data (rd_data)
    );

    // One item at a time; the result register must be free or draining
    assign in_ch.ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ch.ready);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign out_acc     = out_valid_reg && out_ch.ready;
    assign queue_full  = (32'(count_reg) >= QUEUE_DEPTH);
    assign slot_oob    = (SlotCmpW'(in_ch.slot_index) >= SlotCmpW'(QUEUE_DEPTH));

    // Result held while stalled, raised by a finished read or any accepted non-read item
    assign out_valid_next = (out_valid_reg && !out_ch.ready) ||
                            (state_reg == S_READ_WAIT) ||
                            (in_acc && (kind_t'(in_ch.kind) != KIND_READ));

    always_comb
    begin
        status_next  = STAT_IGNORED;
        clipped_next = 1'b0;
        rect_next    = '0;
        slot_next    = '0;
        count_next   = count_reg;
        redraw_next  = redraw_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        unique case (kind_t'(in_ch.kind))
            KIND_UPDATE:
            begin
                // full queue or redraw already pending: absorb
                if (queue_full || redraw_reg)
                begin
                    redraw_next = 1'b1;
                    status_next = STAT_ABSORBED;
                end
                else if (clip.bogus)
                begin
                    status_next = STAT_IGNORED;
                end
                else if (clip.scroll)
                begin
                    // near full-screen: cheaper to redraw it all
                    redraw_next  = 1'b1;
                    status_next  = STAT_ABSORBED;
                    clipped_next = clip.clipped;
                    rect_next    = clip.rect;
                end
                else
                begin
                    wr_en        = in_acc;
                    count_next   = count_reg + 1'b1;
                    status_next  = STAT_STORED;
                    clipped_next = clip.clipped;
                    rect_next    = clip.rect;
                    slot_next    = SlotW'(count_reg);
                end
            end
            KIND_READ:
            begin
                rd_en = in_acc && !slot_oob;
            end
            KIND_CLEAR:
            begin
                count_next  = '0;
                redraw_next = 1'b0;
                status_next = STAT_CLEARED;
            end
            default:
            begin
                status_next = STAT_IGNORED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            redraw_reg    <= 1'b0;
            status_reg    <= STAT_IGNORED;
            clipped_reg   <= 1'b0;
            rect_reg      <= '0;
            slot_reg      <= '0;
            rd_oob_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (kind_t'(in_ch.kind) == KIND_READ)
                        begin
                            // store read in flight; S_READ_WAIT registers the result
                            state_reg  <= S_READ_WAIT;
                            slot_reg   <= in_ch.slot_index;
                            rd_oob_reg <= slot_oob;
                        end
                        else
                        begin
                            status_reg    <= status_next;
                            clipped_reg   <= clipped_next;
                            rect_reg      <= rect_next;
                            slot_reg      <= slot_next;
                            count_reg     <= count_next;
                            redraw_reg    <= redraw_next;
                        end
                    end
                end
                S_READ_WAIT:
                begin
                    state_reg     <= S_IDLE;
                    status_reg    <= STAT_READ;
                    clipped_reg   <= 1'b0;
                    rect_reg      <= rd_oob_reg ? '0 : rd_data;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = status_reg;
    assign out_ch.was_clipped  = clipped_reg;
    assign out_ch.out_x        = rect_reg.x;
    assign out_ch.out_y        = rect_reg.y;
    assign out_ch.out_w        = rect_reg.w;
    assign out_ch.out_h        = rect_reg.h;
    assign out_ch.out_slot     = slot_reg;
    assign out_ch.queued_count = CountW'(count_reg);
    assign out_ch.full_redraw  = redraw_reg;

    // Count never runs past the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= QUEUE_DEPTH)
        else $error("queue count beyond depth");

    // No store write into a full queue or while full redraw is pending
    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (!queue_full && !redraw_reg))
        else $error("store write with queue full or redraw pending");

    // A slot read always passes through S_READ_WAIT and then produces its result
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && kind_t'(in_ch.kind) == KIND_READ) |=>
            (state_reg == S_READ_WAIT && !out_valid_reg) ##1
            (out_valid_reg && status_reg == STAT_READ))
        else $error("slot read result not delivered on time");

    // Clear leaves an empty queue and no redraw pending
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && kind_t'(in_ch.kind) == KIND_CLEAR) |=>
            (count_reg == '0 && !redraw_reg && status_reg == STAT_CLEARED))
        else $error("clear did not empty the queue");

    // A result is never overwritten before it is taken
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ch.ready) |=> (out_valid_reg && $stable(status_reg)))
        else $error("pending result lost");

endmodule

@@ rtl/drcq_cfg.sv @@
// drcq_cfg: APB-style register file holding the framebuffer width and height.
// Depends on drcq_pkg.
module drcq_cfg
    import drcq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [CfgDataW-1:0] pwdata,
    output logic [CfgDataW-1:0] prdata,
    output logic                pready,
    output logic [CoordW-1:0]   fb_width,
    output logic [CoordW-1:0]   fb_height
);

    logic [CoordW-1:0] fb_width_reg;
    logic [CoordW-1:0] fb_height_reg;
    logic              wr_en;
    reg_idx_t          sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign sel    = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_width_reg  <= FbWidthRst;
            fb_height_reg <= FbHeightRst;
        end
        else if (wr_en)
        begin
            unique case (sel)
                REG_FB_WIDTH:  fb_width_reg  <= pwdata[CoordW-1:0];
                REG_FB_HEIGHT: fb_height_reg <= pwdata[CoordW-1:0];
                default:       fb_width_reg  <= fb_width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_FB_WIDTH:  prdata = CfgDataW'(fb_width_reg);
            REG_FB_HEIGHT: prdata = CfgDataW'(fb_height_reg);
            default:       prdata = '0;
        endcase
    end

    assign fb_width  = fb_width_reg;
    assign fb_height = fb_height_reg;

endmodule

@@ rtl/drcq_clip.sv @@
// drcq_clip: clamps an update rectangle to the framebuffer and classifies it.
// Depends on drcq_pkg.
module drcq_clip
    import drcq_pkg::*;
(
    input  logic signed [InW-1:0] rect_x,
    input  logic signed [InW-1:0] rect_y,
    input  logic signed [InW-1:0] rect_w,
    input  logic signed [InW-1:0] rect_h,
    input  logic [CoordW-1:0]     fb_width,
    input  logic [CoordW-1:0]     fb_height,
    output clip_res_t             res
);

    logic signed [InW-1:0] x;
    logic signed [InW-1:0] y;
    logic signed [InW:0]   room_w;
    logic signed [InW:0]   room_h;
    logic signed [InW:0]   rw;
    logic signed [InW:0]   rh;
    logic signed [InW:0]   w;
    logic signed [InW:0]   h;
    logic signed [InW:0]   fw;
    logic signed [InW:0]   half_h;

    always_comb
    begin
        x      = rect_x[InW-1] ? '0 : rect_x;
        y      = rect_y[InW-1] ? '0 : rect_y;
        fw     = $signed({{(InW+1-CoordW){1'b0}}, fb_width});
        half_h = $signed({{(InW+2-CoordW){1'b0}}, fb_height[CoordW-1:1]});
        room_w = fw - $signed({x[InW-1], x});
        room_h = $signed({{(InW+1-CoordW){1'b0}}, fb_height}) - $signed({y[InW-1], y});
        rw     = $signed({rect_w[InW-1], rect_w});
        rh     = $signed({rect_h[InW-1], rect_h});
        w      = (rw < room_w) ? rw : room_w;
        h      = (rh < room_h) ? rh : room_h;

        res.bogus   = w[InW] || h[InW];
        res.clipped = (x != rect_x) || (y != rect_y) || (w != rw) || (h != rh);
        res.scroll  = (w == fw) && (h > half_h);
        res.rect.x  = x[CoordW-1:0];
        res.rect.y  = y[CoordW-1:0];
        res.rect.w  = w[CoordW-1:0];
        res.rect.h  = h[CoordW-1:0];
    end

endmodule

@@ rtl/drcq_rect_mem.sv @@
// drcq_rect_mem: rectangle store, one write and one registered read port.
// Depends on drcq_pkg.
module drcq_rect_mem
    import drcq_pkg::*;
#(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = 3
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  rect_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output rect_t         rd_data
);

    rect_t mem [DEPTH];
    rect_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ bench/dirty_rect_clip_queue_unit_tb.sv @@
// Self-checking bench for dirty_rect_clip_queue_unit: drives update, read,
// clear and unused items, writes the APB registers, and checks every result.
// Depends on drcq_pkg, drcq_if and the RTL top level.
module dirty_rect_clip_queue_unit_tb;
    import drcq_pkg::*;

    localparam int unsigned QueueDepth = 8;

    // One input item as the bench sees it
    typedef struct {
        kind_t                 kind;
        logic signed [InW-1:0] x;
        logic signed [InW-1:0] y;
        logic signed [InW-1:0] w;
        logic signed [InW-1:0] h;
        logic [SlotW-1:0]      slot;
    } rect_item_t;

    // One result item, field for field as on out_ch
    typedef struct {
        status_t           status;
        logic              clipped;
        rect_t             rect;
        logic [SlotW-1:0]  slot;
        logic [CountW-1:0] count;
        logic              redraw;
    } rect_reply_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CfgAddrW-1:0] paddr;
    logic [CfgDataW-1:0] pwdata;
    logic [CfgDataW-1:0] prdata;
    logic                pready;

    drcq_in_if  in_ch();
    drcq_out_if out_ch();

    dirty_rect_clip_queue_unit #(
        .QUEUE_DEPTH(QueueDepth)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // Shadow copy of the block's state, advanced as each item is accepted
    rect_t       shadow_store [QueueDepth];
    int          shadow_count;
    bit          shadow_redraw;
    int          shadow_fb_w;
    int          shadow_fb_h;

    rect_item_t  update_feed[$];   // items not yet offered on in_ch
    rect_reply_t reply_backlog[$]; // results owed by the block, oldest first
    rect_item_t  shown_item;       // item currently offered on in_ch
    int          mismatch_count;

    // Idling control: calm switches off all gaps and stalls
    bit          calm;
    int          src_gap;
    bit          gap_taken;
    logic        src_valid_next;
    int          sink_stall;
    logic        sink_take;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Work out the result of one accepted item and move the shadow state on.
    // A full queue forces full-redraw before anything else is looked at;
    // clipping clamps the corner to zero and cuts the extent to the
    // framebuffer, and a negative extent afterwards means the update is bogus.
    function automatic void clip_and_enqueue(input rect_item_t it);
        rect_reply_t r;
        int rx, ry, rw, rh;
        int x, y, w, h;
        r.status  = STAT_IGNORED;
        r.clipped = 1'b0;
        r.rect    = '0;
        r.slot    = '0;
        case (it.kind)
            KIND_UPDATE:
            begin
                if (shadow_count >= QueueDepth)
                    shadow_redraw = 1'b1;
                if (shadow_redraw)
                    r.status = STAT_ABSORBED;
                else
                begin
                    rx = it.x;
                    ry = it.y;
                    rw = it.w;
                    rh = it.h;
                    x  = (rx > 0) ? rx : 0;
                    y  = (ry > 0) ? ry : 0;
                    w  = (rw < shadow_fb_w - x) ? rw : shadow_fb_w - x;
                    h  = (rh < shadow_fb_h - y) ? rh : shadow_fb_h - y;
                    if (w >= 0 && h >= 0)
                    begin
                        r.clipped = (x != rx) || (y != ry) || (w != rw) || (h != rh);
                        r.rect.x  = x[CoordW-1:0];
                        r.rect.y  = y[CoordW-1:0];
                        r.rect.w  = w[CoordW-1:0];
                        r.rect.h  = h[CoordW-1:0];
                        // full width over more than half the height: treat as scroll
                        if (w == shadow_fb_w && h > shadow_fb_h / 2)
                        begin
                            shadow_redraw = 1'b1;
                            r.status      = STAT_ABSORBED;
                        end
                        else
                        begin
                            r.status = STAT_STORED;
                            r.slot   = shadow_count[SlotW-1:0];
                            shadow_store[shadow_count] = r.rect;
                            shadow_count++;
                        end
                    end
                end
            end
            KIND_READ:
            begin
                r.status = STAT_READ;
                r.rect   = shadow_store[it.slot];
                r.slot   = it.slot;
            end
            KIND_CLEAR:
            begin
                shadow_count  = 0;
                shadow_redraw = 1'b0;
                r.status      = STAT_CLEARED;
            end
            default: ;
        endcase
        r.count  = shadow_count[CountW-1:0];
        r.redraw = shadow_redraw;
        reply_backlog.push_back(r);
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Source side: offers items from update_feed, with random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            src_valid_next = in_ch.valid;
            if (in_ch.valid && in_ch.ready)
            begin
                clip_and_enqueue(shown_item);
                src_valid_next = 1'b0;
            end
            if (!src_valid_next)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (update_feed.size() > 0)
                begin
                    if (!gap_taken && !calm && $urandom_range(0, 5) == 0)
                    begin
                        src_gap   = $urandom_range(1, 17) - 1;
                        gap_taken = 1'b1;
                    end
                    else
                    begin
                        shown_item        = update_feed.pop_front();
                        gap_taken         = 1'b0;
                        in_ch.kind       <= shown_item.kind;
                        in_ch.rect_x     <= shown_item.x;
                        in_ch.rect_y     <= shown_item.y;
                        in_ch.rect_w     <= shown_item.w;
                        in_ch.rect_h     <= shown_item.h;
                        in_ch.slot_index <= shown_item.slot;
                        src_valid_next    = 1'b1;
                    end
                end
            end
            in_ch.valid <= src_valid_next;
        end
    end

    // Sink side: checks each accepted result, stalls ready in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (reply_backlog.size() == 0)
                begin
                    $display("%0t: result with none expected, expected nothing, got status %0d",
                             $time, out_ch.status);
                    mismatch_count++;
                end
                else
                begin
                    rect_reply_t want;
                    want = reply_backlog.pop_front();
                    compare_field("status",       want.status,  out_ch.status);
                    compare_field("was_clipped",  want.clipped, out_ch.was_clipped);
                    compare_field("out_x",        want.rect.x,  out_ch.out_x);
                    compare_field("out_y",        want.rect.y,  out_ch.out_y);
                    compare_field("out_w",        want.rect.w,  out_ch.out_w);
                    compare_field("out_h",        want.rect.h,  out_ch.out_h);
                    compare_field("out_slot",     want.slot,    out_ch.out_slot);
                    compare_field("queued_count", want.count,   out_ch.queued_count);
                    compare_field("full_redraw",  want.redraw,  out_ch.full_redraw);
                end
            end
            if (sink_stall > 0)
            begin
                sink_stall--;
                sink_take = 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                sink_stall = $urandom_range(1, 17) - 1;
                sink_take  = 1'b0;
            end
            else
                sink_take = 1'b1;
            out_ch.ready <= sink_take;
        end
    end

    function automatic rect_item_t make_rect(input kind_t k, input int x, input int y,
                                             input int w, input int h, input int slot);
        rect_item_t it;
        it.kind = k;
        it.x    = InW'(x);
        it.y    = InW'(y);
        it.w    = InW'(w);
        it.h    = InW'(h);
        it.slot = SlotW'(slot);
        return it;
    endfunction

    // Corner coordinate: mostly on screen, some negative, past the edge or anything at all
    function automatic int near_coord(input int lim);
        case ($urandom_range(0, 9))
            0:       return -$urandom_range(1, 64);
            1:       return lim - $urandom_range(0, 3);
            2:       return lim + $urandom_range(1, 64);
            3:       return $urandom_range(0, 65535) - 32768;
            default: return $urandom_range(0, lim);
        endcase
    endfunction

    // Extent: mostly small, some zero, negative, oversized or anything at all
    function automatic int near_extent(input int lim);
        case ($urandom_range(0, 9))
            0:       return -$urandom_range(1, 64);
            1:       return 0;
            2:       return lim + $urandom_range(0, 64);
            3:       return $urandom_range(0, 65535) - 32768;
            default: return $urandom_range(1, lim / 4 + 1);
        endcase
    endfunction

    // Mostly well-formed updates against the current framebuffer; clears are
    // frequent enough that the queue fills and empties many times over
    function automatic rect_item_t random_item();
        rect_item_t it;
        int pick;
        pick = $urandom_range(0, 99);
        it   = make_rect(KIND_UPDATE, $urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 7));
        if (pick < 8)
            // scroll shape: full width from the left, most of the height
            it = make_rect(KIND_UPDATE, -$urandom_range(0, 8),
                           $urandom_range(0, shadow_fb_h / 4),
                           shadow_fb_w + $urandom_range(0, 20), shadow_fb_h, 0);
        else if (pick < 66)
            it = make_rect(KIND_UPDATE, near_coord(shadow_fb_w), near_coord(shadow_fb_h),
                           near_extent(shadow_fb_w), near_extent(shadow_fb_h),
                           $urandom_range(0, 7));
        else if (pick < 72)
            ; // raw noise update as built above
        else if (pick < 84)
            it.kind = KIND_READ;
        else if (pick < 95)
            it.kind = KIND_CLEAR;
        else
            it.kind = KIND_NONE;
        return it;
    endfunction

    // Block is idle once nothing is queued, offered or owed; then allow for
    // the store's registered read path before touching the registers
    task automatic wait_drained();
        do
            @(negedge clk);
        while (update_feed.size() != 0 || in_ch.valid || reply_backlog.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CoordW-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= CfgDataW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_FB_WIDTH)
            shadow_fb_w = value;
        else
            shadow_fb_h = value;
    endtask

    task automatic random_phase(input logic [CoordW-1:0] fb_w, input logic [CoordW-1:0] fb_h,
                                input int count, input bit no_idle);
        write_reg(REG_FB_WIDTH, fb_w);
        write_reg(REG_FB_HEIGHT, fb_h);
        @(negedge clk);
        calm = no_idle;
        repeat (count) update_feed.push_back(random_item());
        wait_drained();
    endtask

    initial
    begin
        // every input known from time zero
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.kind       = KIND_NONE;
        in_ch.rect_x     = '0;
        in_ch.rect_y     = '0;
        in_ch.rect_w     = '0;
        in_ch.rect_h     = '0;
        in_ch.slot_index = '0;
        out_ch.ready     = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        shadow_count     = 0;
        shadow_redraw    = 1'b0;
        shadow_fb_w      = FbWidthRst;
        shadow_fb_h      = FbHeightRst;
        mismatch_count   = 0;
        calm             = 1'b0;
        src_gap          = 0;
        gap_taken        = 1'b0;
        sink_stall       = 0;
        foreach (shadow_store[i])
            shadow_store[i] = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset size of 800 x 600.
        // Fill all eight slots first so that no read ever hits an unwritten
        // entry; the second one starts left of the screen and gets clipped.
        for (int i = 0; i < QueueDepth; i++)
            update_feed.push_back(make_rect(KIND_UPDATE, (i == 1) ? -5 : 10 * i,
                                            20 * i, 30 + i, 40 + i, 0));
        update_feed.push_back(make_rect(KIND_READ, 0, 0, 0, 0, 7));
        update_feed.push_back(make_rect(KIND_READ, 0, 0, 0, 0, 0));
        // queue full: next update switches to full redraw, then stays absorbed
        update_feed.push_back(make_rect(KIND_UPDATE, 1, 2, 3, 4, 0));
        update_feed.push_back(make_rect(KIND_UPDATE, 5, 6, 7, 8, 0));
        // unused kind leaves everything alone
        update_feed.push_back(make_rect(KIND_NONE, -1, -1, -1, -1, 7));
        update_feed.push_back(make_rect(KIND_CLEAR, 0, 0, 0, 0, 0));
        // corner far off screen: negative width after the cut, ignored
        update_feed.push_back(make_rect(KIND_UPDATE, 32767, 0, 10, 10, 0));
        // extreme corner and extent: clipped to the whole screen, seen as scroll
        update_feed.push_back(make_rect(KIND_UPDATE, -32768, -32768, 32767, 32767, 0));
        update_feed.push_back(make_rect(KIND_CLEAR, 0, 0, 0, 0, 0));
        // most negative width: ignored
        update_feed.push_back(make_rect(KIND_UPDATE, 0, 0, -32768, 5, 0));
        // bottom-right pixel, no clipping
        update_feed.push_back(make_rect(KIND_UPDATE, 799, 599, 1, 1, 0));
        // full width at exactly half the height is still stored
        update_feed.push_back(make_rect(KIND_UPDATE, 0, 0, 800, 300, 0));
        // zero-sized rectangle on the far corner
        update_feed.push_back(make_rect(KIND_UPDATE, 800, 600, 0, 0, 0));
        update_feed.push_back(make_rect(KIND_READ, 0, 0, 0, 0, 1));
        update_feed.push_back(make_rect(KIND_CLEAR, 0, 0, 0, 0, 0));
        repeat (110) update_feed.push_back(random_item());
        wait_drained();

        // Random part across several framebuffer sizes, extremes included;
        // the wide one-line phase and the last one run without idling
        random_phase(12'd4095, 12'd4095, 80, 1'b0);
        random_phase(12'd1, 12'd1, 50, 1'b0);
        random_phase(12'd4095, 12'd1, 40, 1'b1);
        random_phase(12'd1, 12'd4095, 40, 1'b0);
        random_phase(12'd640, 12'd480, 70, 1'b0);
        random_phase(FbWidthRst, FbHeightRst, 60, 1'b1);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
